@@ rtl/ddsm_pkg.sv @@
package ddsm_pkg;

	localparam int AXIS_W = 16;
	localparam int WORD_W = 16;
	localparam int Q_W = 34;
	localparam int ANG_W = 34;
	localparam int MAX_ITER = 24;
	localparam int DEF_ITER = 16;
	localparam logic signed [WORD_W-1:0] WORD_MAX = 16'sd32766;
	localparam logic [16:0] WORD_SCALE = 17'd32766;
	localparam logic [16:0] ONE_Q15 = 17'd32768;
	localparam logic signed [Q_W-1:0] ONE_Q30 = 34'sd1073741824;

	typedef enum logic [2:0] {
		REG_ENABLE = 3'd0,
		REG_HOLD = 3'd1,
		REG_MODE = 3'd2,
		REG_LIMIT = 3'd3,
		REG_SKID = 3'd4
	} reg_idx_t;

	// atan(2^-i) in units of 2^32 per turn
	function automatic logic [ANG_W-1:0] atan_lut(input logic [4:0] i);
		case (i)
			5'd0: atan_lut = 34'd536870912;
			5'd1: atan_lut = 34'd316933406;
			5'd2: atan_lut = 34'd167458907;
			5'd3: atan_lut = 34'd85004756;
			5'd4: atan_lut = 34'd42667331;
			5'd5: atan_lut = 34'd21354465;
			5'd6: atan_lut = 34'd10679838;
			5'd7: atan_lut = 34'd5340245;
			5'd8: atan_lut = 34'd2670163;
			5'd9: atan_lut = 34'd1335087;
			5'd10: atan_lut = 34'd667544;
			5'd11: atan_lut = 34'd333772;
			5'd12: atan_lut = 34'd166886;
			5'd13: atan_lut = 34'd83443;
			5'd14: atan_lut = 34'd41722;
			5'd15: atan_lut = 34'd20861;
			5'd16: atan_lut = 34'd10430;
			5'd17: atan_lut = 34'd5215;
			5'd18: atan_lut = 34'd2608;
			5'd19: atan_lut = 34'd1304;
			5'd20: atan_lut = 34'd652;
			5'd21: atan_lut = 34'd326;
			5'd22: atan_lut = 34'd163;
			5'd23: atan_lut = 34'd81;
			default: atan_lut = '0;
		endcase
	endfunction

	// word of a q30 value: trunc(v*32766 >> 30) toward zero
	function automatic logic signed [WORD_W+2:0] to_word(input logic signed [Q_W-1:0] v);
		logic [Q_W-1:0] a;
		logic [Q_W+16:0] p;
		logic [WORD_W+2:0] m;
		a = v[Q_W-1] ? Q_W'(-v) : Q_W'(v);
		p = a * WORD_SCALE;
		m = p[Q_W+14:30];
		to_word = v[Q_W-1] ? -$signed(m) : $signed(m);
	endfunction

	// pipeline payload between stages
	typedef struct packed {
		logic mode;
		logic [16:0] skid;
		logic signed [Q_W-1:0] x;
		logic signed [Q_W-1:0] yl;
		logic signed [Q_W-1:0] yr;
	} axes_t;

	typedef struct packed {
		logic signed [Q_W-1:0] left;
		logic signed [Q_W-1:0] right;
		logic signed [Q_W-1:0] mid;
	} sides_t;

endpackage

@@ rtl/ddsm_cordic.sv @@
module ddsm_cordic import ddsm_pkg::*; #(
	parameter int ITERATIONS = DEF_ITER
) (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic in_valid,
	input axes_t in_axes,
	output logic out_valid,
	output axes_t out_axes,
	output logic [ANG_W-1:0] out_angle
);

	localparam int N = (ITERATIONS > MAX_ITER) ? MAX_ITER : ITERATIONS;

	// one vectoring step per stage
	logic signed [Q_W+1:0] x_s [N+1];
	logic signed [Q_W+1:0] y_s [N+1];
	logic signed [ANG_W+1:0] z_s [N+1];
	logic v_s [N+1];
	axes_t a_s [N+1];

	always_comb begin
		x_s[0] = (Q_W+2)'(in_axes.x[Q_W-1] ? -in_axes.x : in_axes.x);
		y_s[0] = (Q_W+2)'(in_axes.yl[Q_W-1] ? -in_axes.yl : in_axes.yl);
		z_s[0] = '0;
		v_s[0] = in_valid;
		a_s[0] = in_axes;
	end

	for (genvar i = 0; i < N; i++) begin : g_step
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else if (en) begin
				v_s[i+1] <= v_s[i];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				a_s[i+1] <= a_s[i];
				if (y_s[i] > 0) begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + $signed({2'b0, atan_lut(5'(i))});
				end else begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - $signed({2'b0, atan_lut(5'(i))});
				end
			end
		end
	end

	// clamp angle to a quarter turn
	always_comb begin
		out_valid = v_s[N];
		out_axes = a_s[N];
		if (z_s[N] < 0) out_angle = '0;
		else if (z_s[N] > (ANG_W+2)'(ONE_Q30)) out_angle = ANG_W'(ONE_Q30);
		else out_angle = z_s[N][ANG_W-1:0];
	end

endmodule

@@ rtl/ddsm_mix.sv @@
module ddsm_mix import ddsm_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic in_valid,
	input axes_t in_axes,
	input logic [ANG_W-1:0] in_angle,
	output logic out_valid,
	output sides_t out_sides
);

	// stage a: turn coefficient and difference
	logic v_s1, v_s2;
	axes_t a_s1, a_s2;
	logic signed [Q_W:0] tco_s1;
	logic [Q_W-1:0] diff_s1, ax_s1, ay_s1, ax_s2, ay_s2, tm_s2;
	logic tneg_s2;
	logic [Q_W-1:0] ax, ay, dmag;
	logic signed [Q_W+1:0] dd;

	always_comb begin
		ax = in_axes.x[Q_W-1] ? Q_W'(-in_axes.x) : Q_W'(in_axes.x);
		ay = in_axes.yl[Q_W-1] ? Q_W'(-in_axes.yl) : Q_W'(in_axes.yl);
		if (in_axes.mode) dd = (Q_W+2)'(in_axes.yl) - (Q_W+2)'(in_axes.yr);
		else dd = (Q_W+2)'($signed({1'b0, ay})) - (Q_W+2)'($signed({1'b0, ax}));
		dmag = dd[Q_W+1] ? Q_W'(-dd) : Q_W'(dd);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			out_valid <= v_s2;
		end
	end

	// stage b: magnitude multiply for turn
	logic [2*Q_W-1:0] tp;
	logic [Q_W-1:0] tco_mag;
	always_comb begin
		tco_mag = tco_s1[Q_W] ? Q_W'(-tco_s1) : Q_W'(tco_s1);
		tp = (2*Q_W)'(tco_mag[30:0]) * (2*Q_W)'(diff_s1[31:0]);
	end

	// stage c: select sides and mid
	logic signed [Q_W-1:0] turn, mv, l, r;
	logic [Q_W+16:0] mp;
	always_comb begin
		turn = tneg_s2 ? -$signed(tm_s2) : $signed(tm_s2);
		mv = $signed((ax_s2 > ay_s2) ? ax_s2 : ay_s2);
		if (a_s2.mode) begin
			l = a_s2.yl;
			r = a_s2.yr;
			mp = (Q_W+17)'(a_s2.skid) * (Q_W+17)'(tm_s2);
		end else begin
			if (a_s2.x[Q_W-1] == a_s2.yl[Q_W-1]) begin
				l = mv;
				r = turn;
			end else begin
				l = turn;
				r = mv;
			end
			if (a_s2.yl[Q_W-1]) begin
				l = -l;
				r = -r;
			end
			mp = (Q_W+17)'(a_s2.skid) * (Q_W+17)'(ax_s2);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1 <= in_axes;
			tco_s1 <= $signed({in_angle, 1'b0}) - (Q_W+1)'(ONE_Q30);
			diff_s1 <= dmag;
			ax_s1 <= ax;
			ay_s1 <= ay;
			a_s2 <= a_s1;
			ax_s2 <= ax_s1;
			ay_s2 <= ay_s1;
			// two stick mode carries |l-r| through the turn slot
			tm_s2 <= a_s1.mode ? diff_s1 : Q_W'(tp >> 30);
			tneg_s2 <= a_s1.mode ? 1'b0 : tco_s1[Q_W];
			out_sides.left <= l;
			out_sides.right <= r;
			out_sides.mid <= $signed(mp[Q_W+14:15]);
		end
	end

endmodule

@@ rtl/ddsm_words.sv @@
module ddsm_words import ddsm_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic in_valid,
	input sides_t in_sides,
	output logic out_valid,
	output logic [6*WORD_W-1:0] out_words
);

	// stage a: mid times side products
	logic v_s1;
	sides_t s_s1;
	logic signed [Q_W-1:0] ml_s1, mr_s1;

	function automatic logic signed [Q_W-1:0] mshift(input logic signed [Q_W-1:0] m,
		input logic signed [Q_W-1:0] s);
		logic [Q_W-1:0] am, as;
		logic [2*Q_W-1:0] p;
		logic [Q_W-1:0] q;
		am = m[Q_W-1] ? Q_W'(-m) : Q_W'(m);
		as = s[Q_W-1] ? Q_W'(-s) : Q_W'(s);
		p = (2*Q_W)'(am[31:0]) * (2*Q_W)'(as[31:0]);
		q = Q_W'(p >> 30);
		mshift = (m[Q_W-1] != s[Q_W-1]) ? -$signed(q) : $signed(q);
	endfunction

	function automatic logic signed [WORD_W-1:0] sat(input logic signed [WORD_W+3:0] w);
		if (w > (WORD_W+4)'(WORD_MAX)) sat = WORD_MAX;
		else if (w < -(WORD_W+4)'(WORD_MAX)) sat = -WORD_MAX;
		else sat = w[WORD_W-1:0];
	endfunction

	// stage b: words
	logic signed [WORD_W+3:0] wl, wr, dl, dr;
	always_comb begin
		wl = (WORD_W+4)'(to_word(s_s1.left));
		wr = (WORD_W+4)'(to_word(s_s1.right));
		dl = wl - (WORD_W+4)'(to_word(ml_s1));
		dr = wr - (WORD_W+4)'(to_word(mr_s1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			out_valid <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			s_s1 <= in_sides;
			ml_s1 <= mshift(in_sides.mid, in_sides.left);
			mr_s1 <= mshift(in_sides.mid, in_sides.right);
			out_words <= {wr[WORD_W-1:0], sat(dr), wr[WORD_W-1:0],
				wl[WORD_W-1:0], sat(dl), wl[WORD_W-1:0]};
		end
	end

endmodule

@@ rtl/differential_drive_stick_mixer.sv @@
// channel   dir  tdata (low bit up)                              tuser
// s_axis    in   left_x[15:0] left_y[31:16] right_y[47:32]       link_up
// m_axis    out  front_left mid_left back_left front_right
//                mid_right back_right, 16 bits each              -
// cfg       in   cfg_we, cfg_index, cfg_data[15:0]
// one word per cycle while the output is not stalled; the path runs
// through the input stage, the angle stages, three mixing stages and two word stages
// a word with drive disabled, link down or hold set is dropped at input
// the whole pipeline advances together; a stalled output freezes it
// arst_n clears valid bits and sets config registers to their reset values
module differential_drive_stick_mixer import ddsm_pkg::*; #(
	parameter int ANGLE_ITERATIONS = DEF_ITER
) (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	output logic s_axis_tready,
	input logic [47:0] s_axis_tdata, // left_x, left_y, right_y
	input logic s_axis_tuser, // link_up
	output logic m_axis_tvalid,
	input logic m_axis_tready,
	output logic [95:0] m_axis_tdata, // fl, ml, bl, fr, mr, br
	input logic cfg_we,
	input logic [2:0] cfg_index,
	input logic [15:0] cfg_data
);

	logic enable_q, hold_q, mode_q;
	logic [16:0] limit_q, skid_q;
	logic [16:0] cfg_clip;

	// config registers, limit and skid values above one act as one
	assign cfg_clip = (cfg_data > 16'd32768) ? ONE_Q15 : {1'b0, cfg_data};
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
			hold_q <= 1'b0;
			mode_q <= 1'b0;
			limit_q <= ONE_Q15;
			skid_q <= '0;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_ENABLE: enable_q <= cfg_data[0];
				REG_HOLD: hold_q <= cfg_data[0];
				REG_MODE: mode_q <= cfg_data[0];
				REG_LIMIT: limit_q <= cfg_clip;
				REG_SKID: skid_q <= cfg_clip;
				default: ;
			endcase
		end
	end

	logic en;
	assign en = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;

	// input stage: negate y, scale by limit
	logic v_s0;
	axes_t a_s0;
	logic signed [16:0] yln, yrn;
	always_comb begin
		yln = (s_axis_tdata[31:16] == 16'h8000) ? 17'sd32767
			: -$signed({s_axis_tdata[31], s_axis_tdata[31:16]});
		yrn = (s_axis_tdata[47:32] == 16'h8000) ? 17'sd32767
			: -$signed({s_axis_tdata[47], s_axis_tdata[47:32]});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s0 <= 1'b0;
		else if (en) v_s0 <= s_axis_tvalid && s_axis_tuser && enable_q && !hold_q;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s0.mode <= mode_q;
			a_s0.skid <= skid_q;
			a_s0.x <= Q_W'($signed(s_axis_tdata[15:0]) * $signed({1'b0, limit_q}));
			a_s0.yl <= Q_W'(yln * $signed({1'b0, limit_q}));
			a_s0.yr <= Q_W'(yrn * $signed({1'b0, limit_q}));
		end
	end

	logic v_c, v_m;
	axes_t a_c;
	logic [ANG_W-1:0] ang;
	sides_t sides;

	ddsm_cordic #(.ITERATIONS(ANGLE_ITERATIONS)) u_cordic (
		.clk, .arst_n, .en, .in_valid(v_s0), .in_axes(a_s0),
		.out_valid(v_c), .out_axes(a_c), .out_angle(ang)
	);

	ddsm_mix u_mix (
		.clk, .arst_n, .en, .in_valid(v_c), .in_axes(a_c), .in_angle(ang),
		.out_valid(v_m), .out_sides(sides)
	);

	ddsm_words u_words (
		.clk, .arst_n, .en, .in_valid(v_m), .in_sides(sides),
		.out_valid(m_axis_tvalid), .out_words(m_axis_tdata)
	);

`ifndef SYNTHESIS
	a_ready_follows_out: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready == (!m_axis_tvalid || m_axis_tready))
		else $error("ready not tied to output stall");
	a_front_back_left: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[15:0] == m_axis_tdata[47:32])
		else $error("left front and back differ");
	a_front_back_right: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[63:48] == m_axis_tdata[95:80])
		else $error("right front and back differ");
`endif

endmodule

@@ test/differential_drive_stick_mixer_checker.sv @@
module differential_drive_stick_mixer_checker import ddsm_pkg::*; #(
	parameter int ANGLE_ITERATIONS = DEF_ITER
) (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	input logic s_axis_tready,
	input logic [47:0] s_axis_tdata, // left_x, left_y, right_y
	input logic s_axis_tuser, // link_up
	input logic m_axis_tvalid,
	input logic m_axis_tready,
	input logic [95:0] m_axis_tdata, // fl, ml, bl, fr, mr, br
	input logic cfg_we,
	input logic [2:0] cfg_index,
	input logic [15:0] cfg_data,
	output int errors,
	output int pending,
	output int wheel_words_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint ONE30 = 64'sd1073741824;
	localparam longint SCALE = 32766;

	// angle step table, 2^32 per turn
	localparam longint ATAN_STEP [24] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335087, 667544, 333772,
		166886, 83443, 41722, 20861, 10430, 5215,
		2608, 1304, 652, 326, 163, 81
	};

	logic enabled, hold, tank_mode;
	longint limit_q15, skid_q15;
	logic [95:0] wheel_words_due [$];

	function automatic longint mag(input longint v);
		return v < 0 ? -v : v;
	endfunction

	// product shifted, truncated toward zero
	function automatic longint scaled_mul(input longint a, input longint b, input int s);
		longint unsigned m;
		m = (longint'(mag(a)) * longint'(mag(b))) >> s;
		return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
	endfunction

	function automatic longint q30_to_word(input longint v);
		return scaled_mul(v, SCALE, 30);
	endfunction

	function automatic longint stick_angle(input longint ax, input longint ay);
		longint px, py, z, sx, sy;
		int n;
		px = ax;
		py = ay;
		z = 0;
		n = ANGLE_ITERATIONS > 24 ? 24 : ANGLE_ITERATIONS;
		for (int i = 0; i < n; i++) begin
			sx = py >>> i;
			sy = px >>> i;
			if (py > 0) begin
				px += sx; py -= sy; z += ATAN_STEP[i];
			end else begin
				px -= sx; py += sy; z -= ATAN_STEP[i];
			end
		end
		if (z < 0) z = 0;
		if (z > ONE30) z = ONE30;
		return z;
	endfunction

	function automatic longint middle_word(input longint side, input longint red);
		longint w;
		w = q30_to_word(side) - q30_to_word(scaled_mul(red, side, 30));
		if (w > SCALE) w = SCALE;
		if (w < -SCALE) w = -SCALE;
		return w;
	endfunction

	function automatic longint flip_axis(input logic signed [15:0] v);
		return v == -16'sd32768 ? 32767 : -longint'(v);
	endfunction

	// six wheel words of one stick sample
	function automatic logic [95:0] mix_wheels(input logic [47:0] d);
		longint x, yl, yr, lft, rgt, red, ax, ay, tco, turn, move;
		longint w [6];
		logic [95:0] packed_words;
		x = longint'($signed(d[15:0])) * limit_q15;
		yl = flip_axis(d[31:16]) * limit_q15;
		yr = flip_axis(d[47:32]) * limit_q15;
		if (!tank_mode) begin
			ax = mag(x);
			ay = mag(yl);
			tco = 2 * stick_angle(ax, ay) - ONE30;
			turn = scaled_mul(tco, mag(ay - ax), 30);
			move = ax > ay ? ax : ay;
			if (turn > ONE30) turn = ONE30;
			if (turn < -ONE30) turn = -ONE30;
			if (move > ONE30) move = ONE30;
			if ((x >= 0 && yl >= 0) || (x < 0 && yl < 0)) begin
				lft = move; rgt = turn;
			end else begin
				lft = turn; rgt = move;
			end
			if (yl < 0) begin
				lft = -lft; rgt = -rgt;
			end
			red = (skid_q15 * ax) >> 15;
		end else begin
			lft = yl;
			rgt = yr;
			red = (skid_q15 * mag(lft - rgt)) >> 15;
		end
		w[0] = q30_to_word(lft);
		w[1] = middle_word(lft, red);
		w[2] = w[0];
		w[3] = q30_to_word(rgt);
		w[4] = middle_word(rgt, red);
		w[5] = w[3];
		for (int k = 0; k < 6; k++)
			packed_words[16*k +: 16] = w[k][15:0];
		return packed_words;
	endfunction

	assign pending = wheel_words_due.size();

	// register shadow
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled <= 1'b0;
			hold <= 1'b0;
			tank_mode <= 1'b0;
			limit_q15 <= 32768;
			skid_q15 <= 0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ENABLE: enabled <= cfg_data[0];
				REG_HOLD: hold <= cfg_data[0];
				REG_MODE: tank_mode <= cfg_data[0];
				REG_LIMIT: limit_q15 <= cfg_data > 16'd32768 ? 32768 : longint'(cfg_data);
				REG_SKID: skid_q15 <= cfg_data > 16'd32768 ? 32768 : longint'(cfg_data);
				default: ;
			endcase
		end
	end

	// predict on accepted input words
	always @(posedge clk) begin
		if (arst_n && s_axis_tvalid && s_axis_tready && enabled && !hold && s_axis_tuser)
			wheel_words_due.push_back(mix_wheels(s_axis_tdata));
	end

	// compare accepted output words
	initial begin
		errors = 0;
		wheel_words_seen = 0;
	end
	always @(posedge clk) begin
		logic [95:0] exp_w;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			wheel_words_seen++;
			if (wheel_words_due.size() == 0) begin
				errors++;
				$display("%0t: unexpected word %h", $time, m_axis_tdata);
			end else begin
				exp_w = wheel_words_due.pop_front();
				for (int k = 0; k < 6; k++)
					if (exp_w[16*k +: 16] !== m_axis_tdata[16*k +: 16]) begin
						errors++;
						$display("%0t: wheel %0d expected %0d actual %0d", $time, k,
							$signed(exp_w[16*k +: 16]), $signed(m_axis_tdata[16*k +: 16]));
					end
			end
		end
	end
endmodule

@@ test/differential_drive_stick_mixer_tb.sv @@
module differential_drive_stick_mixer_tb import ddsm_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid, s_axis_tready, s_axis_tuser;
	logic [47:0] s_axis_tdata; // left_x, left_y, right_y
	logic m_axis_tvalid, m_axis_tready;
	logic [95:0] m_axis_tdata; // fl, ml, bl, fr, mr, br
	logic cfg_we;
	logic [2:0] cfg_index;
	logic [15:0] cfg_data;
	int errors, pending, wheel_words_seen;
	int tx_idle_pct, rx_idle_pct, ticks_sent;

	always #4 clk = ~clk;

	differential_drive_stick_mixer u_dut (.*);
	differential_drive_stick_mixer_checker u_chk (.*);

	// receiver backpressure
	always @(posedge clk)
		m_axis_tready <= $urandom_range(99) >= rx_idle_pct;

	task automatic send_tick(input logic [15:0] lx, input logic [15:0] ly,
		input logic [15:0] ry, input logic link);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {ry, ly, lx};
		s_axis_tuser <= link;
		do @(posedge clk); while (!s_axis_tready);
		ticks_sent++;
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [15:0] pick_axis();
		case ($urandom_range(9))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return $urandom_range(1) ? 16'h0000 : 16'hffff;
			default: return $urandom;
		endcase
	endfunction

	task automatic random_ticks(input int n);
		for (int i = 0; i < n; i++)
			send_tick(pick_axis(), pick_axis(), pick_axis(), $urandom_range(9) != 0);
	endtask

	initial begin
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		s_axis_tuser <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= REG_ENABLE;
		cfg_data <= '0;
		tx_idle_pct = 19;
		rx_idle_pct = 69;
		ticks_sent = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// disabled after reset: nothing comes out
		send_tick(16'h1234, 16'h8000, 16'h7fff, 1'b1);
		drain();
		write_reg(REG_ENABLE, 16'h0001);
		// extremes and quadrants in arcade mode
		send_tick(16'h0000, 16'h0000, 16'h0000, 1'b1);
		send_tick(16'h8000, 16'h8000, 16'h8000, 1'b1);
		send_tick(16'h7fff, 16'h7fff, 16'h7fff, 1'b1);
		send_tick(16'h7fff, 16'h8000, 16'h0000, 1'b1);
		send_tick(16'h8000, 16'h7fff, 16'h0000, 1'b1);
		send_tick(16'h4000, 16'h0000, 16'h0000, 1'b1);
		send_tick(16'h0000, 16'hc000, 16'h0000, 1'b1);
		send_tick(16'hffff, 16'h0001, 16'h0000, 1'b1);
		send_tick(16'h2000, 16'he000, 16'h0000, 1'b1);
		send_tick(16'h2000, 16'he000, 16'h0000, 1'b0);
		drain();
		// tank mode with full skid and over-range limit
		write_reg(REG_MODE, 16'h0001);
		write_reg(REG_SKID, 16'hffff);
		write_reg(REG_LIMIT, 16'hffff);
		send_tick(16'h0000, 16'h8000, 16'h7fff, 1'b1);
		send_tick(16'h0000, 16'h7fff, 16'h8000, 1'b1);
		send_tick(16'h0000, 16'h8000, 16'h8000, 1'b1);
		send_tick(16'h0000, 16'h1000, 16'hf000, 1'b1);
		drain();
		// hold suppresses words; unused register index is ignored
		write_reg(REG_HOLD, 16'h0001);
		send_tick(16'h0000, 16'h8000, 16'h7fff, 1'b1);
		drain();
		write_reg(REG_HOLD, 16'h0000);
		write_reg(reg_idx_t'(3'd6), 16'hffff);
		send_tick(16'h0100, 16'h8000, 16'h7fff, 1'b1);
		drain();

		// random phases over several settings
		for (int ph = 0; ph < 6; ph++) begin
			if (ph == 2) begin
				tx_idle_pct = 69;
				rx_idle_pct = 19;
			end else if (ph == 4) begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			case (ph)
				0: begin
					write_reg(REG_MODE, 16'h0000);
					write_reg(REG_LIMIT, 16'd32768);
					write_reg(REG_SKID, 16'h0000);
				end
				1: begin
					write_reg(REG_LIMIT, 16'h0000);
					write_reg(REG_SKID, 16'd32768);
				end
				2: begin
					write_reg(REG_LIMIT, $urandom);
					write_reg(REG_SKID, $urandom);
				end
				3: begin
					write_reg(REG_MODE, 16'h0001);
					write_reg(REG_LIMIT, 16'd32768);
					write_reg(REG_SKID, $urandom_range(32768));
				end
				4: begin
					write_reg(REG_LIMIT, $urandom_range(32768));
					write_reg(REG_SKID, $urandom);
				end
				default: begin
					write_reg(REG_MODE, 16'h0000);
					write_reg(REG_LIMIT, $urandom_range(32768));
					write_reg(REG_SKID, $urandom_range(32768));
				end
			endcase
			random_ticks(100);
			drain();
		end

		$display("covered %0d stick ticks, %0d wheel words checked, both mixing modes",
			ticks_sent, wheel_words_seen);
		$display("register sweep included disable, hold, limit and skid extremes");
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin
		#5000000;
		$display("simulation failed");
		$finish;
	end
endmodule
